/* design/olist_pkg.sv */
// olist_pkg: shared types and constants for the ordered list store
// holds beat structs, command and status codes, controller states and
// the command and status bundles between controller and datapath
`default_nettype none

package olist_pkg;

    // store geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int ECNT_W   = 5;

    // command codes
    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_POP     = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // input beat
    typedef struct packed {
        logic [1:0]              command;
        logic signed [VAL_W-1:0] item_value;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] removed_value;
        logic [ECNT_W-1:0]       entry_count;
    } t_out_beat;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_POP_FIN
    } t_state;

    // read address select
    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_LAST
    } t_rd_sel;

    // write address and data select
    typedef enum logic {
        WR_APPEND,
        WR_SHIFT
    } t_wr_sel;

    // removed value select for the result
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_VAL,
        RES_RD
    } t_res_sel;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       idx_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       finish;
        logic [1:0] fin_status;
        t_res_sel   res_sel;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       empty;
        logic       match;
        logic       idx_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/olist_ctrl.sv */
// olist_ctrl: command sequencer for the ordered list store
// walks search and gap closing one entry at a time; uses olist_pkg
`default_nettype none

module olist_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  olist_pkg::t_dp_stat i_stat,
    output logic                busy,
    output olist_pkg::t_dp_cmd  o_cmd
);
    import olist_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                if (i_stat.cmd == CMD_REMOVE && !i_stat.empty) begin
                    n_state = S_SRCH_RD;
                end else if (i_stat.cmd == CMD_POP && !i_stat.empty) begin
                    n_state = S_POP_FIN;
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (i_stat.match) begin
                    n_state = S_SHIFT_RD;
                end else if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: n_state = i_stat.idx_last ? S_IDLE : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_POP_FIN:  n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_IDX;
        o_cmd.wr_sel     = WR_APPEND;
        o_cmd.fin_status = STAT_OK;
        o_cmd.res_sel    = RES_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DISPATCH: begin
                unique case (i_stat.cmd)
                    CMD_APPEND: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.fin_status = STAT_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_stat.empty) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = STAT_NOT_FOUND;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = STAT_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_LAST;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            S_SRCH_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_SRCH_CMP: begin
                if (!i_stat.match) begin
                    if (i_stat.idx_last) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.fin_status = STAT_NOT_FOUND;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_sel = RES_VAL;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_SHIFT;
                o_cmd.idx_inc = 1'b1;
            end
            S_POP_FIN: begin
                o_cmd.cnt_dec = 1'b1;
                o_cmd.finish  = 1'b1;
                o_cmd.res_sel = RES_RD;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* design/olist_dp.sv */
// olist_dp: entry memory, fill count, walk index and result register
// driven by olist_ctrl through command and status bundles; uses olist_pkg
`default_nettype none

module olist_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  olist_pkg::t_in_beat  i_in,
    input  olist_pkg::t_dp_cmd   i_cmd,
    output olist_pkg::t_dp_stat  o_stat,
    output logic                 o_done,
    output olist_pkg::t_out_beat o_out
);
    import olist_pkg::*;

    logic [VAL_W-1:0] r_mem [CAPACITY];

    logic [1:0]       r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [VAL_W-1:0] r_rd_data;
    logic             r_done;
    t_out_beat        r_out;
    t_out_beat        n_out;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [CNT_W-1:0] idx_next;

    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);

    // beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in.command;
            r_val <= i_in.item_value;
        end
    end

    // walk index and fill count
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_next[IDX_W-1:0];
        end
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // memory addresses and write data
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_IDX:  rd_addr = r_idx;
            RD_NEXT: rd_addr = idx_next[IDX_W-1:0];
            RD_LAST: rd_addr = IDX_W'(r_count - CNT_W'(1));
            default: rd_addr = r_idx;
        endcase
        if (i_cmd.wr_sel == WR_SHIFT) begin
            wr_addr = r_idx;
            wr_data = r_rd_data;
        end else begin
            wr_addr = IDX_W'(r_count);
            wr_data = r_val;
        end
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // status to controller
    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.full     = (r_count >= CNT_W'(CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.match    = (r_rd_data == r_val);
        o_stat.idx_last = (idx_next >= r_count);
    end

    // result beat
    always_comb begin
        n_out.status      = i_cmd.fin_status;
        n_out.entry_count = ECNT_W'(n_count);
        case (i_cmd.res_sel)
            RES_VAL: n_out.removed_value = r_val;
            RES_RD:  n_out.removed_value = r_rd_data;
            default: n_out.removed_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

`default_nettype wire

/* design/ordered_list_store.sv */
// Ordered list store: keeps up to CAPACITY (16) signed 32-bit values in
// insertion order and takes one command at a time: append at the tail,
// remove the first entry equal to a value and close the gap, or pop the
// tail. A command is taken when start is high and busy is low; its single
// result beat appears on o_out for exactly one cycle with o_done high, and
// the receiver cannot stall it. Append, unknown commands, and a remove or
// pop on an empty store finish straight from dispatch; a pop otherwise
// first reads the tail entry. Remove-value walks the entries from the head,
// a read and then a compare per entry, and on a match closes the gap one
// entry at a time, reading the next entry and writing it one place toward
// the head, on the entry memory with its separate read and write ports and
// its registered read. busy drops in the cycle the result is shown, so the
// next command can be taken then. The store needs no clearing after reset.
`default_nettype none

module ordered_list_store (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  olist_pkg::t_in_beat  i_in,
    output logic                 busy,
    output logic                 o_done,
    output olist_pkg::t_out_beat o_out
);
    import olist_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // command sequencer
    olist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    // storage and result register
    olist_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_done  (o_done),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // count never goes past the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out.entry_count <= ECNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    // a full report only comes with a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status == STAT_FULL) |-> (o_out.entry_count == ECNT_W'(CAPACITY)))
        else $error("full status with store not full");

    // an accepted command holds busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // a result beat shows only once the sequencer is back in idle, never twice in a row
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && !$past(o_done)))
        else $error("result beat while busy or repeated");
`endif

endmodule

`default_nettype wire
